// ----- design/topk_order_select_defines.svh -----
// assertion macros used by topk_order_select
// checks compile away when SYNTH is defined
`ifndef TOPK_ORDER_SELECT_DEFINES_SVH
`define TOPK_ORDER_SELECT_DEFINES_SVH

`ifndef SYNTH
`define TOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TOS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOS_ASSERT(lbl, prop, msg)
`define TOS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- design/tos_pkg.sv -----
`timescale 1ns / 1ps

package tos_pkg;

  localparam int VALUE_W       = 32;
  localparam int KEEP_W        = 11;
  localparam int CMD_W         = 2;
  localparam int STAT_W        = 2;
  localparam int MAX_ITEMS_DEF = 1024;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [KEEP_W-1:0]  keep_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_QUERY = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

endpackage

// ----- design/tos_if.sv -----
`timescale 1ns / 1ps

interface tos_in_if;
  import tos_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   command;
  value_t value;
  keep_t  keep_count;
  keep_t  position;

  modport source (output valid, output command, output value, output keep_count,
                  output position, input ready);
  modport sink (input valid, input command, input value, input keep_count,
                input position, output ready);
endinterface

interface tos_out_if;
  import tos_pkg::*;
  logic    valid;
  logic    ready;
  value_t  result_value;
  status_t status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

// ----- design/tos_store.sv -----
`timescale 1ns / 1ps

module tos_store #(
  parameter int MAX_ITEMS = tos_pkg::MAX_ITEMS_DEF,
  parameter int AW        = 10
) (
  input  logic                   clk,
  input  logic                   val_we,
  input  logic [AW-1:0]          val_wa,
  input  tos_pkg::value_t        val_wd,
  input  logic                   rank_we,
  input  logic [AW-1:0]          rank_wa,
  input  logic [AW-1:0]          rank_wd,
  input  logic [AW-1:0]          rd_addr,
  output tos_pkg::value_t        val_q,
  output logic [AW-1:0]          rank_q
);
  import tos_pkg::*;

  value_t          val_mem  [MAX_ITEMS];
  logic [AW-1:0]   rank_mem [MAX_ITEMS];

  // one write port and one registered read port on each array
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    rank_q <= rank_mem[rd_addr];
  end

endmodule

// ----- design/topk_order_select.sv -----
`timescale 1ns / 1ps
// topk_order_select: p-th of the k largest stored values, counted in load order
// in_ch carries requests: command (load, query, clear), value, keep_count, position.
// out_ch returns one result per request: result_value and status.
// load, clear and the unused code: the request goes straight to the final step.
// a query first re-ranks the store if it changed since the last ranking:
//   one shared compare unit walks every pair of the n stored values.
// the query then scans stored ranks in load order and stops at the selected
//   value, at the latest at the end of the store.
// a bad query (keep count zero or above the count, position zero or above keep
//   count) finishes at once with status 2 and a zero value.
// one request is in work at a time: in_ch.ready is high only while idle, so a
//   new request is not taken until the previous one has left the final step.
// the result sits in an output register; a stalled receiver holds the block in
//   its final step until the previous result is taken.
// reset empties the store and marks ranks stale; memory contents are not cleared.
`include "topk_order_select_defines.svh"

module topk_order_select #(
  parameter int MAX_ITEMS = tos_pkg::MAX_ITEMS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tos_in_if.sink    in_ch,
  tos_out_if.source out_ch
);
  import tos_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int QW = (CW > KEEP_W) ? CW : KEEP_W;
  localparam int XW = (AW > KEEP_W) ? AW : KEEP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_BUILD_I, S_BUILD_LATCH, S_BUILD_SCAN, S_QSCAN, S_DONE
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic            ranks_ready_r;
  logic [CW-1:0]   bi_r;
  logic [CW-1:0]   j_r;
  logic            pv_r;
  logic [CW-1:0]   pj_r;
  value_t          vi_r;
  logic [AW-1:0]   rcnt_r;
  keep_t           seen_r;
  keep_t           k_r;
  keep_t           p_r;
  value_t          res_r;
  status_t         st_r;
  logic            out_valid_r;
  value_t          out_value_r;
  status_t         out_status_r;

  logic            accept;
  logic            not_full;
  logic            bad_query;
  logic            issue;
  logic            beats;
  logic            kept;
  logic            val_we;
  logic            rank_we;
  logic [AW-1:0]   rd_addr;
  value_t          val_q;
  logic [AW-1:0]   rank_q;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;

  assign not_full  = (count_r < CW'(MAX_ITEMS));
  assign bad_query = (in_ch.keep_count == '0) ||
                     (QW'(in_ch.keep_count) > QW'(count_r)) ||
                     (in_ch.position == '0) ||
                     (in_ch.position > in_ch.keep_count);

  assign issue = (j_r < count_r);
  // shared compare: element pj beats row element bi (larger, or equal and loaded earlier)
  assign beats = (val_q > vi_r) || ((val_q == vi_r) && (pj_r < bi_r));
  assign kept  = (XW'(rank_q) < XW'(k_r));

  assign val_we  = accept && (in_ch.command == CMD_LOAD) && not_full;
  assign rank_we = (state_r == S_BUILD_SCAN) && !issue && !pv_r;
  assign rd_addr = (state_r == S_BUILD_I) ? bi_r[AW-1:0] : j_r[AW-1:0];

  tos_store #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .val_we  (val_we),
    .val_wa  (count_r[AW-1:0]),
    .val_wd  (in_ch.value),
    .rank_we (rank_we),
    .rank_wa (bi_r[AW-1:0]),
    .rank_wd (rcnt_r),
    .rd_addr (rd_addr),
    .val_q   (val_q),
    .rank_q  (rank_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      ranks_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
      pv_r          <= 1'b0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            st_r  <= ST_OK;
            res_r <= '0;
            k_r   <= in_ch.keep_count;
            p_r   <= in_ch.position;
            state_r <= S_DONE;
            case (in_ch.command)
              CMD_LOAD: begin
                if (not_full) begin
                  count_r       <= count_r + CW'(1);
                  ranks_ready_r <= 1'b0;
                end else begin
                  st_r <= ST_FULL;
                end
              end
              CMD_QUERY: begin
                if (bad_query) begin
                  st_r <= ST_BAD;
                end else if (!ranks_ready_r) begin
                  bi_r    <= '0;
                  state_r <= S_BUILD_I;
                end else begin
                  j_r     <= '0;
                  seen_r  <= '0;
                  pv_r    <= 1'b0;
                  state_r <= S_QSCAN;
                end
              end
              CMD_CLEAR: begin
                count_r       <= '0;
                ranks_ready_r <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_BUILD_I: begin
          state_r <= S_BUILD_LATCH;
        end
        S_BUILD_LATCH: begin
          vi_r    <= val_q;
          j_r     <= '0;
          rcnt_r  <= '0;
          pv_r    <= 1'b0;
          state_r <= S_BUILD_SCAN;
        end
        S_BUILD_SCAN: begin
          // read of column j is issued now and compared in the next cycle, when its data is back
          pv_r <= issue;
          pj_r <= j_r;
          if (issue) begin
            j_r <= j_r + CW'(1);
          end
          if (pv_r && beats) begin
            rcnt_r <= rcnt_r + AW'(1);
          end
          if (!issue && !pv_r) begin
            if ((bi_r + CW'(1)) == count_r) begin
              ranks_ready_r <= 1'b1;
              j_r           <= '0;
              seen_r        <= '0;
              state_r       <= S_QSCAN;
            end else begin
              bi_r    <= bi_r + CW'(1);
              state_r <= S_BUILD_I;
            end
          end
        end
        S_QSCAN: begin
          pv_r <= issue;
          pj_r <= j_r;
          if (issue) begin
            j_r <= j_r + CW'(1);
          end
          if (pv_r && kept) begin
            seen_r <= seen_r + KEEP_W'(1);
            if ((seen_r + KEEP_W'(1)) == p_r) begin
              res_r   <= val_q;
              pv_r    <= 1'b0;
              state_r <= S_DONE;
            end
          end else if (!issue && !pv_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_r;
            out_status_r <= st_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `TOS_ASSERT(a_err_zero,
    out_valid_r && out_status_r != ST_OK |-> out_value_r == '0,
    "error result with nonzero value")
  `TOS_ASSERT(a_count_max, count_r <= CW'(MAX_ITEMS), "item count above capacity")
  `TOS_ASSERT(a_scan_ranked, state_r == S_QSCAN |-> ranks_ready_r,
    "query scan on stale ranks")
  `TOS_ASSERT(a_full_hold,
    accept && in_ch.command == CMD_LOAD && !not_full |=> count_r == CW'(MAX_ITEMS),
    "dropped load changed count")
  `TOS_ASSERT_RST(a_rst_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r,
    "reset did not idle block")

endmodule
